// ===== rtl/core/bracket_language_tokenizer_top_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef BRACKET_LANGUAGE_TOKENIZER_TOP_DEFINES_SVH
`define BRACKET_LANGUAGE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define BLT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define BLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bltok_pkg.sv =====
// Shared types, constants and character classes of the bracket-language tokenizer.
package bltok_pkg;

    localparam longint unsigned TEXT_BYTES_DEF = 64'd1048576;

    localparam int FIELD_W   = 21;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 4;
    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int M_TDATA_W = ((4 * FIELD_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        K_END    = 4'd0,
        K_LBR    = 4'd1,
        K_RBR    = 4'd2,
        K_COLON  = 4'd3,
        K_ARROW  = 4'd4,
        K_STRING = 4'd5,
        K_INT    = 4'd6,
        K_DEC    = 4'd7,
        K_SYMBOL = 4'd8,
        K_ERROR  = 4'd9
    } token_kind_t;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COMMENT = 3'd1,
        M_STRING  = 3'd2,
        M_MINUS   = 3'd3,
        M_INT     = 3'd4,
        M_INT_DOT = 3'd5,
        M_DEC     = 3'd6,
        M_SYMBOL  = 3'd7
    } scan_mode_t;

    typedef struct packed {
        token_kind_t        kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] col;
        logic               last;
    } token_t;

    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_LBR    = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBR    = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // + - * / < > = ! ? %
    function automatic logic is_opchar(input logic [BYTE_W-1:0] c);
        return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
               (c == 8'h3C) || (c == 8'h3E) || (c == 8'h3D) || (c == 8'h21) ||
               (c == 8'h3F) || (c == 8'h25);
    endfunction

    function automatic logic sym_start(input logic [BYTE_W-1:0] c);
        return is_alpha(c) || (c == CH_USCORE) || is_opchar(c);
    endfunction

    function automatic logic sym_part(input logic [BYTE_W-1:0] c);
        return sym_start(c) || is_digit(c);
    endfunction

endpackage

// ===== rtl/core/bltok_lexer.sv =====
// Lexer state and per-byte token logic: one byte in, up to four tokens out.
module bltok_lexer import bltok_pkg::*; #(
    parameter longint unsigned TEXT_BYTES = TEXT_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [BYTE_W-1:0]    text_byte,
    input  logic                 end_of_text,
    output token_t               toks [MAX_RES],
    output logic [RES_CNT_W-1:0] tok_cnt
);

    localparam int POS_W = $clog2(TEXT_BYTES + 1);
    localparam logic [POS_W:0]   LIMIT = (POS_W + 1)'(TEXT_BYTES);
    localparam logic [POS_W-1:0] ZERO  = '0;
    localparam logic [POS_W-1:0] ONE   = POS_W'(1);
    localparam logic [POS_W-1:0] TWO   = POS_W'(2);

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > LIMIT) begin
            s = LIMIT;
        end
        return s[POS_W-1:0];
    endfunction

    function automatic token_t mk_tok(input token_kind_t k, input logic [POS_W-1:0] st,
                                      input logic [POS_W-1:0] ln, input logic [POS_W-1:0] li,
                                      input logic [POS_W-1:0] co, input logic lst);
        token_t t;
        t.kind  = k;
        t.start = FIELD_W'(st);
        t.len   = FIELD_W'(ln);
        t.line  = FIELD_W'(li);
        t.col   = FIELD_W'(co);
        t.last  = lst;
        return t;
    endfunction

    scan_mode_t       mode_reg, mode_next;
    logic             esc_reg, esc_next;
    logic             ended_reg, ended_next;
    logic [POS_W-1:0] off_reg, off_next;
    logic [POS_W-1:0] line_reg, line_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] tstart_reg, tstart_next;
    logic [POS_W-1:0] tline_reg, tline_next;
    logic [POS_W-1:0] tcol_reg, tcol_next;
    logic [POS_W-1:0] tcnt_reg, tcnt_next;

    logic                 restart;
    logic [RES_CNT_W-1:0] n;

    always_comb begin
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        ended_next  = ended_reg;
        off_next    = off_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        tcnt_next   = tcnt_reg;
        restart     = 1'b0;
        n           = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            toks[i] = '0;
        end

        if (!ended_reg) begin
            if (text_byte != CH_NUL) begin
                // byte against the token in progress
                unique case (mode_reg)
                    M_COMMENT: begin
                        if (text_byte == CH_LF) begin
                            mode_next = M_IDLE;
                        end
                    end
                    M_STRING: begin
                        if (esc_reg) begin
                            esc_next  = 1'b0;
                            tcnt_next = sat_add(tcnt_reg, TWO);
                        end else if (text_byte == CH_BSLASH) begin
                            esc_next = 1'b1;
                        end else if (text_byte == CH_DQUOTE) begin
                            toks[n[RES_IDX_W-1:0]] = mk_tok(K_STRING, tstart_reg, tcnt_reg,
                                                            tline_reg, tcol_reg, 1'b0);
                            n         = n + 1'b1;
                            mode_next = M_IDLE;
                        end else begin
                            tcnt_next = sat_add(tcnt_reg, ONE);
                        end
                    end
                    M_MINUS: begin
                        if (text_byte == CH_GT) begin
                            tcnt_next = TWO;
                            toks[n[RES_IDX_W-1:0]] = mk_tok(K_ARROW, tstart_reg, TWO,
                                                            tline_reg, tcol_reg, 1'b0);
                            n         = n + 1'b1;
                            mode_next = M_IDLE;
                        end else if (is_digit(text_byte)) begin
                            tcnt_next = TWO;
                            mode_next = M_INT;
                        end else if (sym_part(text_byte)) begin
                            tcnt_next = TWO;
                            mode_next = M_SYMBOL;
                        end else begin
                            toks[n[RES_IDX_W-1:0]] = mk_tok(K_SYMBOL, tstart_reg, tcnt_reg,
                                                            tline_reg, tcol_reg, 1'b0);
                            n       = n + 1'b1;
                            restart = 1'b1;
                        end
                    end
                    M_INT: begin
                        if (is_digit(text_byte)) begin
                            tcnt_next = sat_add(tcnt_reg, ONE);
                        end else if (text_byte == CH_DOT) begin
                            mode_next = M_INT_DOT;
                        end else begin
                            toks[n[RES_IDX_W-1:0]] = mk_tok(K_INT, tstart_reg, tcnt_reg,
                                                            tline_reg, tcol_reg, 1'b0);
                            n       = n + 1'b1;
                            restart = 1'b1;
                        end
                    end
                    M_INT_DOT: begin
                        if (is_digit(text_byte)) begin
                            tcnt_next = sat_add(tcnt_reg, TWO);
                            mode_next = M_DEC;
                        end else begin
                            // number stops before the dot; dot is an error token
                            toks[n[RES_IDX_W-1:0]] = mk_tok(K_INT, tstart_reg, tcnt_reg,
                                                            tline_reg, tcol_reg, 1'b0);
                            n = n + 1'b1;
                            toks[n[RES_IDX_W-1:0]] = mk_tok(K_ERROR,
                                                            sat_add(tstart_reg, tcnt_reg),
                                                            ONE, tline_reg,
                                                            sat_add(tcol_reg, tcnt_reg),
                                                            1'b0);
                            n       = n + 1'b1;
                            restart = 1'b1;
                        end
                    end
                    M_DEC: begin
                        if (is_digit(text_byte)) begin
                            tcnt_next = sat_add(tcnt_reg, ONE);
                        end else begin
                            toks[n[RES_IDX_W-1:0]] = mk_tok(K_DEC, tstart_reg, tcnt_reg,
                                                            tline_reg, tcol_reg, 1'b0);
                            n       = n + 1'b1;
                            restart = 1'b1;
                        end
                    end
                    M_SYMBOL: begin
                        if (sym_part(text_byte)) begin
                            tcnt_next = sat_add(tcnt_reg, ONE);
                        end else begin
                            toks[n[RES_IDX_W-1:0]] = mk_tok(K_SYMBOL, tstart_reg, tcnt_reg,
                                                            tline_reg, tcol_reg, 1'b0);
                            n       = n + 1'b1;
                            restart = 1'b1;
                        end
                    end
                    M_IDLE: begin
                        restart = 1'b1;
                    end
                endcase

                // byte opens a new lexeme
                if (restart) begin
                    mode_next   = M_IDLE;
                    tstart_next = off_reg;
                    tline_next  = line_reg;
                    tcol_next   = col_reg;
                    tcnt_next   = ONE;
                    priority if (is_space(text_byte)) begin
                        mode_next = M_IDLE;
                    end else if (text_byte == CH_SEMI) begin
                        mode_next = M_COMMENT;
                    end else if (text_byte == CH_LBR) begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_LBR, off_reg, ONE, line_reg,
                                                        col_reg, 1'b0);
                        n = n + 1'b1;
                    end else if (text_byte == CH_RBR) begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_RBR, off_reg, ONE, line_reg,
                                                        col_reg, 1'b0);
                        n = n + 1'b1;
                    end else if (text_byte == CH_COLON) begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_COLON, off_reg, ONE, line_reg,
                                                        col_reg, 1'b0);
                        n = n + 1'b1;
                    end else if (text_byte == CH_DQUOTE) begin
                        mode_next   = M_STRING;
                        tstart_next = sat_add(off_reg, ONE);
                        tcnt_next   = ZERO;
                        esc_next    = 1'b0;
                    end else if (text_byte == CH_MINUS) begin
                        mode_next = M_MINUS;
                    end else if (is_digit(text_byte)) begin
                        mode_next = M_INT;
                    end else if (sym_start(text_byte)) begin
                        mode_next = M_SYMBOL;
                    end else begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_ERROR, off_reg, ONE, line_reg,
                                                        col_reg, 1'b0);
                        n = n + 1'b1;
                    end
                end

                off_next = sat_add(off_reg, ONE);
                if (text_byte == CH_LF) begin
                    line_next = sat_add(line_reg, ONE);
                    col_next  = ONE;
                end else begin
                    col_next = sat_add(col_reg, ONE);
                end
            end

            // end of text: flush pending lexeme, then the closing end token
            if ((text_byte == CH_NUL) || end_of_text) begin
                unique case (mode_next)
                    M_STRING: begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_STRING, tstart_next, tcnt_next,
                                                        tline_next, tcol_next, 1'b0);
                        n = n + 1'b1;
                    end
                    M_MINUS: begin
                        tcnt_next = ONE;
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_SYMBOL, tstart_next, ONE,
                                                        tline_next, tcol_next, 1'b0);
                        n = n + 1'b1;
                    end
                    M_INT: begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_INT, tstart_next, tcnt_next,
                                                        tline_next, tcol_next, 1'b0);
                        n = n + 1'b1;
                    end
                    M_INT_DOT: begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_INT, tstart_next, tcnt_next,
                                                        tline_next, tcol_next, 1'b0);
                        n = n + 1'b1;
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_ERROR,
                                                        sat_add(tstart_next, tcnt_next),
                                                        ONE, tline_next,
                                                        sat_add(tcol_next, tcnt_next), 1'b0);
                        n = n + 1'b1;
                    end
                    M_DEC: begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_DEC, tstart_next, tcnt_next,
                                                        tline_next, tcol_next, 1'b0);
                        n = n + 1'b1;
                    end
                    M_SYMBOL: begin
                        toks[n[RES_IDX_W-1:0]] = mk_tok(K_SYMBOL, tstart_next, tcnt_next,
                                                        tline_next, tcol_next, 1'b0);
                        n = n + 1'b1;
                    end
                    M_IDLE, M_COMMENT: begin
                    end
                endcase
                mode_next  = M_IDLE;
                esc_next   = 1'b0;
                toks[n[RES_IDX_W-1:0]] = mk_tok(K_END, off_next, ZERO, line_next,
                                                col_next, 1'b1);
                n          = n + 1'b1;
                ended_next = 1'b1;
            end
        end
        tok_cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            esc_reg    <= 1'b0;
            ended_reg  <= 1'b0;
            off_reg    <= ZERO;
            line_reg   <= ONE;
            col_reg    <= ONE;
            tstart_reg <= ZERO;
            tline_reg  <= ONE;
            tcol_reg   <= ONE;
            tcnt_reg   <= ZERO;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            ended_reg  <= ended_next;
            off_reg    <= off_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            tcnt_reg   <= tcnt_next;
        end
    end

endmodule

// ===== rtl/core/bracket_language_tokenizer_top.sv =====
// Top level of the streaming bracket-language tokenizer.
//
// Source text streams in one byte per request on the s_axis side (tdata = byte,
// tlast = final byte of the text); tokens stream out one per request on the
// m_axis side. A byte is caught in an input register and lexed once the result
// buffer is empty or its last token is being taken, writing all the tokens it
// causes (zero to four) into the four-slot result buffer at once. The buffer
// shifts out one token per cycle while m_axis_tready is high, slot 0 driving the
// outputs. Throughput is one byte per cycle while each byte yields at most one
// token and m_axis_tready stays high; a byte that yields more holds the next
// byte until the result buffer drains. The first token of a byte shows tvalid
// once the byte has passed the input register and been loaded into the result
// buffer. A zero byte, or tlast on a byte, flushes the pending lexeme and then
// closes the text with an end token that carries tlast; later bytes are accepted
// and dropped until reset. Offset, line, column and length saturate at TEXT_BYTES.
module bracket_language_tokenizer_top import bltok_pkg::*; #(
    parameter longint unsigned TEXT_BYTES = TEXT_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // source byte requests
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] text_byte
    input  logic                 s_axis_tlast,   // end_of_text
    // token requests
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [20:0] start_offset, [41:21] token_length, [62:42] line_number,
    // [83:63] column_number, [87:84] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]    m_axis_tuser,   // [3:0] token_kind
    output logic                 m_axis_tlast    // last_token
);

    // input register
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // result buffer, slot 0 is the output
    token_t               buf_reg [MAX_RES];
    logic [RES_CNT_W-1:0] cnt_reg;

    token_t               toks [MAX_RES];
    logic [RES_CNT_W-1:0] tok_cnt;
    logic                 load;
    logic                 pop;

    // the lexer may step once the buffer is empty or about to be
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign load = in_vld_reg &&
                  ((cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && m_axis_tready));
    assign s_axis_tready = !in_vld_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_vld_reg <= 1'b1;
        end else if (load) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    bltok_lexer #(
        .TEXT_BYTES (TEXT_BYTES)
    ) u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (load),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .toks        (toks),
        .tok_cnt     (tok_cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= tok_cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MAX_RES; i++) begin
                buf_reg[i] <= toks[i];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tuser  = buf_reg[0].kind;
    assign m_axis_tlast  = buf_reg[0].last;
    assign m_axis_tdata  = {(M_TDATA_W - 4 * FIELD_W)'(0), buf_reg[0].col, buf_reg[0].line,
                            buf_reg[0].len, buf_reg[0].start};

`include "bracket_language_tokenizer_top_defines.svh"

    // buffer never holds more than one byte's worth of tokens
    `BLT_ASSERT_SAME(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= RES_CNT_W'(MAX_RES),
                     "result buffer count out of range")
    // end token is the last thing ever produced
    `BLT_ASSERT_NEXT(a_quiet_after_end, aclk, aresetn, pop && m_axis_tlast, !m_axis_tvalid,
                     "token after end of text")
    // a held byte is not lost while the buffer drains
    `BLT_ASSERT_NEXT(a_hold_byte, aclk, aresetn, in_vld_reg && !load, in_vld_reg,
                     "input byte dropped while stalled")

endmodule
